// ----- sv/i2crm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2crm_pkg: shared types and constants
// Opcodes, phases, byte roles and the front-to-back request struct.
// ----------------------------------------------------------------------------
package i2crm_pkg;

  localparam int WRITE_DEPTH = 16;
  localparam int QW = $clog2(WRITE_DEPTH);
  localparam int FILL_W = $clog2(WRITE_DEPTH + 1);

  // packed result word: scl, sda, drive, byte, valid, last, done, status, busy
  localparam int RES_W = 17;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_PUSH  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic CFG_TICKS = 1'b0;
  localparam logic CFG_POLL  = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOACK  = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  typedef enum logic [14:0] {
    PH_IDLE       = 15'b000000000000001,
    PH_START_HI   = 15'b000000000000010,
    PH_START_LO   = 15'b000000000000100,
    PH_TX_SETUP   = 15'b000000000001000,
    PH_TX_HIGH    = 15'b000000000010000,
    PH_TX_HOLD    = 15'b000000000100000,
    PH_ACK_REL    = 15'b000000001000000,
    PH_ACK_HIGH   = 15'b000000010000000,
    PH_ACK_POLL   = 15'b000000100000000,
    PH_RX_LOW     = 15'b000001000000000,
    PH_RX_HIGH    = 15'b000010000000000,
    PH_RXACK_LOW  = 15'b000100000000000,
    PH_RXACK_HIGH = 15'b001000000000000,
    PH_STOP_LO    = 15'b010000000000000,
    PH_STOP_HI    = 15'b100000000000000
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_DEV_W = 3'd0,
    ROLE_REG   = 3'd1,
    ROLE_DATA  = 3'd2,
    ROLE_DEV_R = 3'd3,
    ROLE_RX    = 3'd4,
    ROLE_FAIL  = 3'd5
  } role_t;

  // classified request from the front part, one per tick
  typedef struct packed {
    logic       push;
    logic [7:0] wdata;
    logic       start;
    logic       rd;
    logic [6:0] dev;
    logic [7:0] reg_a;
    logic [7:0] cnt;
    logic       sda;
  } req_t;

endpackage

// ----- sv/i2crm_front.sv -----
// ----------------------------------------------------------------------------
// i2crm_front: request intake
// Decodes the opcode and classifies each request for the sequencer.
// ----------------------------------------------------------------------------
module i2crm_front (
  input  logic            [1:0] in_opcode,
  input  logic            [6:0] in_dev_addr,
  input  logic            [7:0] in_reg_addr,
  input  logic            [7:0] in_byte_count,
  input  logic            [7:0] in_write_data,
  input  logic                  in_sda_in,
  output i2crm_pkg::req_t       req
);
  always_comb begin
    req.push  = (in_opcode == i2crm_pkg::OP_PUSH);
    req.wdata = in_write_data;
    req.start = (in_opcode == i2crm_pkg::OP_WRITE) || (in_opcode == i2crm_pkg::OP_READ);
    req.rd    = (in_opcode == i2crm_pkg::OP_READ);
    req.dev   = in_dev_addr;
    req.reg_a = in_reg_addr;
    req.cnt   = in_byte_count;
    req.sda   = in_sda_in;
  end
endmodule

// ----- sv/i2crm_back.sv -----
// ----------------------------------------------------------------------------
// i2crm_back: bus sequencer
// Runs the write queue and the bit-level start, byte, ack and stop phases.
// ----------------------------------------------------------------------------
module i2crm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  i2crm_pkg::req_t     req,
  input  logic         [15:0] ticks,
  input  logic          [7:0] poll_limit,
  output logic                scl,
  output logic                sda_o,
  output logic                sda_oe,
  output logic          [7:0] rbyte,
  output logic                rvalid,
  output logic                rlast,
  output logic                done,
  output logic          [1:0] stat,
  output logic                busy
);
  localparam int WRITE_DEPTH_L = i2crm_pkg::WRITE_DEPTH;

  i2crm_pkg::phase_t phase_r, phase_nxt;
  i2crm_pkg::role_t  role_r, role_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [7:0]  sh_r, sh_nxt;
  logic [18:0] dly_r, dly_nxt;
  logic [7:0]  poll_r, poll_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [6:0]  dev_r, dev_nxt;
  logic [7:0]  reg_r, reg_nxt;
  logic        rd_r, rd_nxt;
  logic        scl_r, scl_nxt, so_r, so_nxt, oe_r, oe_nxt;

  // write queue as a circular buffer, head byte kept in a register
  logic [7:0] q_mem [WRITE_DEPTH_L];
  logic [i2crm_pkg::QW-1:0]     rp_r, wp_r, rp_nxt;
  logic [i2crm_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic [7:0] hd_r;
  logic pop, wr;

  logic [15:0] t_eff;
  logic [18:0] u1, u2, u4;
  assign t_eff = (ticks == 16'd0) ? 16'd1 : ticks;
  assign u1 = {3'd0, t_eff};
  assign u2 = {2'd0, t_eff, 1'b0};
  assign u4 = {1'b0, t_eff, 2'b0};

  // a pop on the same tick frees a slot for the push
  assign wr = step && req.push &&
              ((fill_r != i2crm_pkg::FILL_W'(WRITE_DEPTH_L)) || pop);

  assign rp_nxt   = !pop ? rp_r :
                    (rp_r == i2crm_pkg::QW'(WRITE_DEPTH_L - 1)) ? '0 : rp_r + 1'b1;
  assign fill_nxt = fill_r + i2crm_pkg::FILL_W'(wr) - i2crm_pkg::FILL_W'(pop);

  always_ff @(posedge clk) begin
    if (wr) q_mem[wp_r] <= req.wdata;
    // head follows the read pointer; a push into an empty queue goes straight in
    if (wr && (fill_r == i2crm_pkg::FILL_W'(pop))) hd_r <= req.wdata;
    else hd_r <= q_mem[rp_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r <= '0; wp_r <= '0; fill_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == i2crm_pkg::QW'(WRITE_DEPTH_L - 1)) ? '0 : wp_r + 1'b1;
      rp_r <= rp_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_comb begin
    logic [7:0] qb;
    logic fin;
    phase_nxt = phase_r; role_nxt = role_r; bit_nxt = bit_r; sh_nxt = sh_r;
    dly_nxt = dly_r; poll_nxt = poll_r; left_nxt = left_r; dev_nxt = dev_r;
    reg_nxt = reg_r; rd_nxt = rd_r; scl_nxt = scl_r; so_nxt = so_r; oe_nxt = oe_r;
    rbyte = '0; rvalid = 1'b0; rlast = 1'b0; done = 1'b0; stat = i2crm_pkg::ST_OK;
    pop = 1'b0; fin = 1'b0;
    qb = (fill_r != '0) ? hd_r : 8'd0;
    if (step) begin
      if (phase_r == i2crm_pkg::PH_ACK_POLL) begin
        if (!req.sda) begin
          fin = 1'b1;
        end else if (poll_r >= poll_limit) begin
          role_nxt = i2crm_pkg::ROLE_FAIL;
          phase_nxt = i2crm_pkg::PH_STOP_LO; dly_nxt = u4;
          scl_nxt = 1'b0; so_nxt = 1'b0; oe_nxt = 1'b1;
        end else begin
          poll_nxt = poll_r + 8'd1;
        end
      end else if (phase_r != i2crm_pkg::PH_IDLE && dly_r > 19'd1) begin
        dly_nxt = dly_r - 19'd1;
      end else begin
        unique case (phase_r)
          i2crm_pkg::PH_IDLE: ;
          i2crm_pkg::PH_START_HI: begin
            phase_nxt = i2crm_pkg::PH_START_LO; dly_nxt = u4;
            scl_nxt = 1'b1; so_nxt = 1'b0; oe_nxt = 1'b1;
          end
          i2crm_pkg::PH_START_LO: begin
            bit_nxt = '0;
            phase_nxt = i2crm_pkg::PH_TX_SETUP; dly_nxt = u2;
            scl_nxt = 1'b0; so_nxt = sh_r[7]; oe_nxt = 1'b1;
          end
          i2crm_pkg::PH_TX_SETUP: begin
            phase_nxt = i2crm_pkg::PH_TX_HIGH; dly_nxt = u2; scl_nxt = 1'b1; oe_nxt = 1'b1;
          end
          i2crm_pkg::PH_TX_HIGH: begin
            phase_nxt = i2crm_pkg::PH_TX_HOLD; dly_nxt = u2; scl_nxt = 1'b0; oe_nxt = 1'b1;
          end
          i2crm_pkg::PH_TX_HOLD: begin
            if (bit_r >= 4'd7) begin
              poll_nxt = '0;
              phase_nxt = i2crm_pkg::PH_ACK_REL; dly_nxt = u1;
              scl_nxt = 1'b0; so_nxt = 1'b1; oe_nxt = 1'b0;
            end else begin
              bit_nxt = bit_r + 4'd1;
              sh_nxt = {sh_r[6:0], 1'b0};
              phase_nxt = i2crm_pkg::PH_TX_SETUP; dly_nxt = u2;
              scl_nxt = 1'b0; so_nxt = sh_r[6]; oe_nxt = 1'b1;
            end
          end
          i2crm_pkg::PH_ACK_REL: begin
            phase_nxt = i2crm_pkg::PH_ACK_HIGH; dly_nxt = u1;
            scl_nxt = 1'b1; so_nxt = 1'b1; oe_nxt = 1'b0;
          end
          i2crm_pkg::PH_ACK_HIGH: begin
            phase_nxt = i2crm_pkg::PH_ACK_POLL; dly_nxt = u1;
            scl_nxt = 1'b1; so_nxt = 1'b1; oe_nxt = 1'b0;
          end
          i2crm_pkg::PH_ACK_POLL: ;
          i2crm_pkg::PH_RX_LOW: begin
            phase_nxt = i2crm_pkg::PH_RX_HIGH; dly_nxt = u1;
            scl_nxt = 1'b1; so_nxt = 1'b1; oe_nxt = 1'b0;
          end
          i2crm_pkg::PH_RX_HIGH: begin
            sh_nxt = {sh_r[6:0], req.sda};
            if (bit_r >= 4'd7) begin
              rvalid = 1'b1; rbyte = sh_nxt; rlast = (left_r <= 8'd1);
              left_nxt = (left_r != 8'd0) ? left_r - 8'd1 : 8'd0;
              phase_nxt = i2crm_pkg::PH_RXACK_LOW; dly_nxt = u2;
              scl_nxt = 1'b0; so_nxt = (left_nxt == 8'd0); oe_nxt = 1'b1;
            end else begin
              bit_nxt = bit_r + 4'd1;
              phase_nxt = i2crm_pkg::PH_RX_LOW; dly_nxt = u2;
              scl_nxt = 1'b0; so_nxt = 1'b1; oe_nxt = 1'b0;
            end
          end
          i2crm_pkg::PH_RXACK_LOW: begin
            phase_nxt = i2crm_pkg::PH_RXACK_HIGH; dly_nxt = u2; scl_nxt = 1'b1; oe_nxt = 1'b1;
          end
          i2crm_pkg::PH_RXACK_HIGH: begin
            if (left_r == 8'd0) begin
              phase_nxt = i2crm_pkg::PH_STOP_LO; dly_nxt = u4;
              scl_nxt = 1'b0; so_nxt = 1'b0; oe_nxt = 1'b1;
            end else begin
              role_nxt = i2crm_pkg::ROLE_RX; bit_nxt = '0; sh_nxt = '0;
              phase_nxt = i2crm_pkg::PH_RX_LOW; dly_nxt = u2;
              scl_nxt = 1'b0; so_nxt = 1'b1; oe_nxt = 1'b0;
            end
          end
          i2crm_pkg::PH_STOP_LO: begin
            phase_nxt = i2crm_pkg::PH_STOP_HI; dly_nxt = u4;
            scl_nxt = 1'b1; so_nxt = 1'b1; oe_nxt = 1'b1;
          end
          i2crm_pkg::PH_STOP_HI: begin
            done = 1'b1;
            stat = (role_r == i2crm_pkg::ROLE_FAIL) ? i2crm_pkg::ST_NOACK : i2crm_pkg::ST_OK;
            phase_nxt = i2crm_pkg::PH_IDLE; dly_nxt = '0;
            scl_nxt = 1'b1; so_nxt = 1'b1; oe_nxt = 1'b1;
          end
          default: ;
        endcase
      end

      // byte acknowledged: pick the next byte, or go to stop when none is left
      if (fin) begin
        logic do_wr;
        do_wr = 1'b0;
        scl_nxt = 1'b0;
        unique case (role_r)
          i2crm_pkg::ROLE_DEV_W: begin
            role_nxt = i2crm_pkg::ROLE_REG; sh_nxt = reg_r; bit_nxt = '0;
            phase_nxt = i2crm_pkg::PH_TX_SETUP; dly_nxt = u2;
            so_nxt = reg_r[7]; oe_nxt = 1'b1;
          end
          i2crm_pkg::ROLE_REG: begin
            if (rd_r) begin
              role_nxt = i2crm_pkg::ROLE_DEV_R; sh_nxt = {dev_r, 1'b1};
              phase_nxt = i2crm_pkg::PH_START_HI; dly_nxt = u4;
              scl_nxt = 1'b1; so_nxt = 1'b1; oe_nxt = 1'b1;
            end else do_wr = 1'b1;
          end
          i2crm_pkg::ROLE_DEV_R: begin
            if (left_r == 8'd0) begin
              phase_nxt = i2crm_pkg::PH_STOP_LO; dly_nxt = u4; so_nxt = 1'b0; oe_nxt = 1'b1;
            end else begin
              role_nxt = i2crm_pkg::ROLE_RX; bit_nxt = '0; sh_nxt = '0;
              phase_nxt = i2crm_pkg::PH_RX_LOW; dly_nxt = u2; so_nxt = 1'b1; oe_nxt = 1'b0;
            end
          end
          default: do_wr = 1'b1;
        endcase
        if (do_wr) begin
          if (left_r == 8'd0) begin
            phase_nxt = i2crm_pkg::PH_STOP_LO; dly_nxt = u4; so_nxt = 1'b0; oe_nxt = 1'b1;
          end else begin
            pop = (fill_r != '0);
            left_nxt = left_r - 8'd1;
            role_nxt = i2crm_pkg::ROLE_DATA; sh_nxt = qb; bit_nxt = '0;
            phase_nxt = i2crm_pkg::PH_TX_SETUP; dly_nxt = u2; so_nxt = qb[7]; oe_nxt = 1'b1;
          end
        end
      end

      // a pop only happens mid-transfer, so an idle start sees the plain fill
      if (req.start) begin
        if (phase_nxt != i2crm_pkg::PH_IDLE || (!req.rd && (req.cnt > 8'(fill_r)))) begin
          if (!done) stat = i2crm_pkg::ST_REJECT;
        end else begin
          dev_nxt = req.dev; reg_nxt = req.reg_a; left_nxt = req.cnt; rd_nxt = req.rd;
          role_nxt = i2crm_pkg::ROLE_DEV_W; sh_nxt = {req.dev, 1'b0};
          bit_nxt = '0; poll_nxt = '0;
          phase_nxt = i2crm_pkg::PH_START_HI; dly_nxt = u4;
          scl_nxt = 1'b1; so_nxt = 1'b1; oe_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= i2crm_pkg::PH_IDLE; role_r <= i2crm_pkg::ROLE_DEV_W;
      bit_r <= '0; sh_r <= '0; dly_r <= '0; poll_r <= '0; left_r <= '0;
      dev_r <= '0; reg_r <= '0; rd_r <= 1'b0;
      scl_r <= 1'b1; so_r <= 1'b1; oe_r <= 1'b1;
    end else begin
      phase_r <= phase_nxt; role_r <= role_nxt; bit_r <= bit_nxt; sh_r <= sh_nxt;
      dly_r <= dly_nxt; poll_r <= poll_nxt; left_r <= left_nxt;
      dev_r <= dev_nxt; reg_r <= reg_nxt; rd_r <= rd_nxt;
      scl_r <= scl_nxt; so_r <= so_nxt; oe_r <= oe_nxt;
    end
  end

  assign scl    = scl_nxt;
  assign sda_o  = so_nxt;
  assign sda_oe = oe_nxt;
  assign busy   = (phase_nxt != i2crm_pkg::PH_IDLE);
endmodule

// ----- sv/i2crm_outq.sv -----
// ----------------------------------------------------------------------------
// i2crm_outq: result skid buffer
// Two-entry queue that holds results while the consumer stalls.
// ----------------------------------------------------------------------------
module i2crm_outq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [i2crm_pkg::RES_W-1:0] din,
  output logic                        space,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [i2crm_pkg::RES_W-1:0] dout
);
  logic [i2crm_pkg::RES_W-1:0] e0_r, e1_r;
  logic [1:0]  cnt_r;
  logic        pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign dout      = e0_r;
  // room for one more while the head may still wait
  assign space     = (cnt_r != 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      e0_r <= (cnt_r == 2'd2) ? e1_r : din;
      if (cnt_r == 2'd2 && push) e1_r <= din;
    end else if (push) begin
      if (cnt_r == 2'd0) e0_r <= din;
      else e1_r <= din;
    end
  end
endmodule

// ----- sv/i2c_register_master.sv -----
// ----------------------------------------------------------------------------
// i2c_register_master: I2C register read/write master
// One request is one bus tick; the sequencer emits one result per tick.
// ----------------------------------------------------------------------------
// channel | ports                    | meaning
// in      | in_valid / in_ready      | one request = one bus tick
// out     | out_valid / out_ready    | line levels and status for that tick
// cfg     | cfg_we, cfg_index, data  | tick scale, ack poll limit
//
// one request per clock when the result side keeps up
// the sequencer advances once per accepted request; a two-entry result
// queue lets a new request in while the previous result waits
// in_ready drops only when the result queue is full
// synchronous active-low reset: bus idle, queue empty, registers at defaults
module i2c_register_master (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [6:0]  in_dev_addr,
  input  logic [7:0]  in_reg_addr,
  input  logic [7:0]  in_byte_count,
  input  logic [7:0]  in_write_data,
  input  logic        in_sda_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_scl_level,
  output logic        out_sda_level,
  output logic        out_sda_drive,
  output logic [7:0]  out_read_byte,
  output logic        out_read_valid,
  output logic        out_read_last,
  output logic        out_done_res,
  output logic [1:0]  out_status,
  output logic        out_busy_res,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  logic [15:0] ticks_r;
  logic [7:0]  poll_r;
  i2crm_pkg::req_t req;
  logic step, space;
  logic scl, so, oe, rv, rl, dn, bz;
  logic [7:0] rb;
  logic [1:0] st;
  logic [i2crm_pkg::RES_W-1:0] dout;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= 16'd1;
      poll_r  <= 8'd250;
    end else if (cfg_we) begin
      if (cfg_index == i2crm_pkg::CFG_TICKS) ticks_r <= cfg_data;
      else poll_r <= cfg_data[7:0];
    end
  end

  assign in_ready = space;
  assign step     = in_valid && in_ready;

  i2crm_front u_front (
    .in_opcode, .in_dev_addr, .in_reg_addr, .in_byte_count, .in_write_data,
    .in_sda_in, .req
  );

  i2crm_back u_back (
    .clk, .rst_n, .step, .req, .ticks(ticks_r), .poll_limit(poll_r),
    .scl, .sda_o(so), .sda_oe(oe), .rbyte(rb), .rvalid(rv), .rlast(rl),
    .done(dn), .stat(st), .busy(bz)
  );

  i2crm_outq u_outq (
    .clk, .rst_n, .push(step),
    .din({scl, so, oe, rb, rv, rl, dn, st, bz}),
    .space, .out_valid, .out_ready, .dout
  );

  assign {out_scl_level, out_sda_level, out_sda_drive, out_read_byte, out_read_valid,
          out_read_last, out_done_res, out_status, out_busy_res} = dout;
endmodule

// ----- sv/i2crm_checker.sv -----
// ----------------------------------------------------------------------------
// i2crm_checker: port-level checks
// Watches the result channel of the master.
// ----------------------------------------------------------------------------
module i2crm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_read_valid,
  input logic       out_read_last,
  input logic [7:0] out_read_byte,
  input logic       out_done_res,
  input logic [1:0] out_status
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_byte))
    else $error("result changed while stalled");
  a_last_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_last |-> out_read_valid)
    else $error("read_last without read_valid");
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_read_valid |-> out_read_byte == 8'd0)
    else $error("stray read byte");
  a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_status != 2'd2)
    else $error("reject status on done");
endmodule

bind i2c_register_master i2crm_checker u_chk (
  .clk, .rst_n, .out_valid, .out_ready, .out_read_valid, .out_read_last,
  .out_read_byte, .out_done_res, .out_status
);
